// ===== src/odma_pkg.sv =====
// types and constants shared by the sprite-table copy engine
`default_nettype none
package odma_pkg;

	localparam logic [15:0] OAM_BASE      = 16'hFE00;
	localparam logic [7:0]  PAGE_FOLD_MIN = 8'hF0;
	localparam logic [7:0]  PAGE_FOLD_SUB = 8'h50;

	typedef enum logic [1:0] {
		OP_TICK  = 2'd0,
		OP_WRITE = 2'd1,
		OP_READ  = 2'd2
	} odma_op_t;

	typedef struct packed {
		logic [1:0] opcode;
		logic [7:0] write_value;
		logic [7:0] bus_read_data;
	} odma_req_t;

	typedef struct packed {
		logic [7:0]  register_data;
		logic        busy_res;
		logic        bus_write_valid;
		logic [15:0] bus_write_address;
		logic [7:0]  bus_write_data;
		logic        bus_read_valid;
		logic [15:0] bus_read_address;
	} odma_rsp_t;

	typedef struct packed {
		logic [7:0] page;
		logic       active;
		logic [8:0] read_idx;
		logic [8:0] write_idx;
		logic [3:0] divider;
		logic [7:0] held;
		logic       read_pending;
	} odma_state_t;

endpackage
`default_nettype wire

// ===== src/odma_step.sv =====
// next-state and result logic for one transaction of the copy engine
`default_nettype none
module odma_step #(
	parameter int TRANSFER_LENGTH = 160,
	parameter int TICKS_PER_STEP  = 4
) (
	input  odma_pkg::odma_state_t state,
	input  odma_pkg::odma_req_t   req,
	output odma_pkg::odma_state_t state_next,
	output odma_pkg::odma_rsp_t   rsp
);
	import odma_pkg::*;

	localparam logic [8:0] LEN = 9'(TRANSFER_LENGTH);
	localparam logic [4:0] TPS = 5'(TICKS_PER_STEP);

	logic [7:0]  page_adj;
	logic [4:0]  div_inc;
	logic [8:0]  widx_new;

	assign page_adj = (req.write_value >= PAGE_FOLD_MIN) ?
		(req.write_value - PAGE_FOLD_SUB) : req.write_value;
	assign div_inc = {1'b0, state.divider} + 5'd1;

	always_comb begin
		state_next = state;
		rsp        = '0;
		widx_new   = state.write_idx;
		case (req.opcode)
			OP_WRITE: begin
				state_next.page         = page_adj;
				state_next.divider      = '0;
				state_next.read_idx     = '0;
				state_next.write_idx    = '0;
				state_next.held         = '0;
				state_next.read_pending = 1'b0;
				state_next.active       = 1'b1;
			end
			OP_READ: begin
				rsp.register_data = state.page;
			end
			OP_TICK: begin
				// the answer to last read lands before any write on this tick
				if (state.read_pending) begin
					state_next.held         = req.bus_read_data;
					state_next.read_pending = 1'b0;
				end
				if (state.active) begin
					if (div_inc < TPS) begin
						state_next.divider = div_inc[3:0];
					end else begin
						state_next.divider = '0;
						if (state.read_idx != '0) begin
							rsp.bus_write_valid   = 1'b1;
							rsp.bus_write_address = OAM_BASE + {7'd0, state.write_idx};
							rsp.bus_write_data    = state_next.held;
							widx_new              = state.write_idx + 9'd1;
						end
						if (state.read_idx < LEN) begin
							rsp.bus_read_valid      = 1'b1;
							rsp.bus_read_address    = {state.page, 8'd0} +
								{7'd0, state.read_idx};
							state_next.read_idx     = state.read_idx + 9'd1;
							state_next.read_pending = 1'b1;
						end
						state_next.write_idx = widx_new;
						if (widx_new >= LEN) begin
							state_next.active = 1'b0;
						end
					end
				end
			end
			default: begin
			end
		endcase
		rsp.busy_res = state_next.active;
	end

endmodule
`default_nettype wire

// ===== src/oam_dma_copy_engine.sv =====
// top level of the sprite-table copy engine: input register, state and result register
//
// One request channel (req_valid / req_ready / req) carries ticks, register
// writes and register reads; one response channel (rsp_valid / rsp_ready /
// rsp) returns exactly one response per request, in order.
// A register write starts or restarts a copy of TRANSFER_LENGTH bytes from
// the written page (less 50h if F0h or above) into sprite memory; every
// TICKS_PER_STEP ticks the response carries one sprite-memory write and/or
// one source read, with its data expected in bus_read_data of the next tick.
// A taken request waits in the input register; its response is registered
// in the output register, which holds rsp_valid high until it is taken.
// Throughput: one transaction per clock while responses are taken, set by the single
// pass from the input register through the step logic to the output register.
// When rsp_ready is low the response is held and one more request can sit in
// the input register; req_ready then drops until the response is taken.
// Reset (arst_n low) empties both registers and clears the page, counters
// and busy flag.
`default_nettype none
module oam_dma_copy_engine #(
	parameter int TRANSFER_LENGTH = 160,
	parameter int TICKS_PER_STEP  = 4
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                req_valid,
	output logic                req_ready,
	input  odma_pkg::odma_req_t req,
	output logic                rsp_valid,
	input  logic                rsp_ready,
	output odma_pkg::odma_rsp_t rsp
);
	import odma_pkg::*;

	logic        valid_s1;
	odma_req_t   req_s1;
	logic        rsp_valid_q;
	odma_rsp_t   rsp_q;
	odma_state_t state_q;
	odma_state_t state_next;
	odma_rsp_t   rsp_next;
	logic        advance;

	assign advance   = valid_s1 && (!rsp_valid_q || rsp_ready);
	assign req_ready = !valid_s1 || advance;
	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	odma_step #(
		.TRANSFER_LENGTH(TRANSFER_LENGTH),
		.TICKS_PER_STEP (TICKS_PER_STEP)
	) u_step (
		.state     (state_q),
		.req       (req_s1),
		.state_next(state_next),
		.rsp       (rsp_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1    <= 1'b0;
			rsp_valid_q <= 1'b0;
			state_q     <= '0;
		end else begin
			if (req_ready) begin
				valid_s1 <= req_valid;
			end
			if (advance) begin
				rsp_valid_q <= 1'b1;
				state_q     <= state_next;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req_valid && req_ready) begin
			req_s1 <= req;
		end
		if (advance) begin
			rsp_q <= rsp_next;
		end
	end

	// writes never run ahead of reads
	a_write_behind_read: assert property (@(posedge clk) disable iff (!arst_n)
		state_q.write_idx <= state_q.read_idx)
		else $error("write index ahead of read index");

	// a source read always leaves an answer pending for the next tick
	a_read_sets_pending: assert property (@(posedge clk) disable iff (!arst_n)
		advance && rsp_next.bus_read_valid |=> state_q.read_pending)
		else $error("read issued without pending flag");

	// a response stalled by the receiver is not overwritten
	a_stalled_rsp_held: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid_q && !rsp_ready |=> rsp_valid_q && $stable(rsp_q))
		else $error("stalled response changed");

	// an idle engine issues no bus traffic
	a_idle_no_bus: assert property (@(posedge clk) disable iff (!arst_n)
		advance && !state_q.active |-> !rsp_next.bus_write_valid && !rsp_next.bus_read_valid)
		else $error("bus traffic while idle");

endmodule
`default_nettype wire
